// ===== rtl/lmq_pkg.sv =====
// lmq_pkg: shared types and constants for the LWE mod-q MAC codec.
// No dependencies; imported by lwe_mod_q_mac_codec_top, lmq_modmul and lmq_finish.
package lmq_pkg;

  // Modulus register value after reset
  localparam int unsigned MOD_RESET = 8210;

  // Finishing modes, read from the last item of a sum
  localparam logic [1:0] MODE_KEY = 2'd0;  // sum + noise
  localparam logic [1:0] MODE_V   = 2'd1;  // sum + noise + msg * floor(q/2)
  localparam logic [1:0] MODE_DEC = 2'd2;  // decode bit from cipher_v - sum

  // Status of the bit-serial modular multiplier
  typedef struct packed {
    logic busy;  // a product is in flight
    logic done;  // last step happens this cycle
  } lmq_mul_stat_t;

endpackage

// ===== rtl/lmq_if.sv =====
// lmq_if: valid/ready channel interfaces for operand items and result items.
// Depends on nothing; widths follow the W parameter of each instance.
interface lmq_op_if #(parameter int W = 14);
  logic         valid;
  logic         ready;
  logic [1:0]   mode;
  logic [W-1:0] a_value;
  logic [W-1:0] b_value;
  logic         last;
  logic [W-1:0] noise;
  logic         msg_bit;
  logic [W-1:0] cipher_v;

  modport source (output valid, mode, a_value, b_value, last, noise, msg_bit, cipher_v,
                  input ready);
  modport sink   (input valid, mode, a_value, b_value, last, noise, msg_bit, cipher_v,
                  output ready);
endinterface

interface lmq_res_if #(parameter int W = 14);
  logic         valid;
  logic         ready;
  logic [W-1:0] value;
  logic         range_error;

  modport source (output valid, value, range_error, input ready);
  modport sink   (input valid, value, range_error, output ready);
endinterface

// ===== rtl/lwe_mod_q_mac_codec_top.sv =====
// lwe_mod_q_mac_codec_top: mod-q multiply-accumulate with LWE finishing modes.
// Uses lmq_pkg, lmq_if, lmq_modmul and lmq_finish.
//
//   channel   | dir | handshake      | payload
//   ----------+-----+----------------+------------------------------------------
//   operand   | in  | valid/ready    | mode a_value b_value last noise msg_bit
//             |     |                | cipher_v
//   result    | out | valid/ready    | value range_error
//   modulus   | in  | modulus_we     | modulus_data
//
// Each operand item is accepted in idle, then steps through the serial
// multiplier one modulus bit at a time; a last item then passes through a
// finishing state. The result register decouples the output side; a new
// operand is taken while a result still waits, and finishing holds only if the
// result register is still full. Synchronous reset clears the sum, error flag
// and modulus (to 8210) with no clearing pass.
module lwe_mod_q_mac_codec_top #(
  parameter int MOD_WIDTH = 14
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 modulus_we,
  input  logic [MOD_WIDTH-1:0] modulus_data,
  lmq_op_if.sink               operand,
  lmq_res_if.source            result
);
  import lmq_pkg::*;

  localparam logic [MOD_WIDTH-1:0] ModReset = MOD_WIDTH'(MOD_RESET);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MUL  = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  logic [1:0]           state;
  logic [MOD_WIDTH-1:0] modulus;
  logic [MOD_WIDTH-1:0] q_eff;
  logic [MOD_WIDTH-1:0] running_sum;
  logic                 error_seen;

  // Latched fields of the item in flight
  logic [1:0]           mode;
  logic                 last;
  logic [MOD_WIDTH-1:0] noise;
  logic                 msg_bit;
  logic [MOD_WIDTH-1:0] cipher_v;

  // Result register
  logic                 out_valid;
  logic [MOD_WIDTH-1:0] out_value;
  logic                 out_err;

  logic                 accept;
  logic                 op_bad;
  logic [MOD_WIDTH-1:0] a_gated;
  logic [MOD_WIDTH-1:0] mul_result;
  lmq_mul_stat_t        mul_stat;
  logic [MOD_WIDTH-1:0] fin_value;
  logic                 fin_err;
  logic                 out_free;

  // Modulus values below 2 act as 2
  assign q_eff = (modulus < MOD_WIDTH'(2)) ? MOD_WIDTH'(2) : modulus;

  assign operand.ready = (state == ST_IDLE);
  assign accept        = operand.valid && operand.ready;
  assign op_bad        = (operand.a_value >= q_eff) || (operand.b_value >= q_eff);
  assign a_gated       = op_bad ? '0 : operand.a_value;  // bad pair only reduces the sum
  assign out_free      = !out_valid || result.ready;

  lmq_modmul #(.W(MOD_WIDTH)) u_modmul (
    .clk    (clk),
    .rst    (rst),
    .start  (accept),
    .q      (q_eff),
    .sum_in (running_sum),
    .a_in   (a_gated),
    .b_in   (operand.b_value),
    .result (mul_result),
    .stat   (mul_stat)
  );

  lmq_finish #(.W(MOD_WIDTH)) u_finish (
    .mode        (mode),
    .q           (q_eff),
    .sum         (running_sum),
    .noise       (noise),
    .msg_bit     (msg_bit),
    .cipher_v    (cipher_v),
    .value       (fin_value),
    .range_error (fin_err)
  );

  // Control: sequencer, sum, error flag, modulus
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      modulus     <= ModReset;
      running_sum <= '0;
      error_seen  <= 1'b0;
    end else begin
      if (modulus_we) begin
        modulus <= modulus_data;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            error_seen <= error_seen | op_bad;
            state      <= ST_MUL;
          end
        end
        ST_MUL: begin
          if (mul_stat.done) begin
            running_sum <= mul_result;
            state       <= last ? ST_FIN : ST_IDLE;
          end
        end
        ST_FIN: begin
          if (out_free) begin
            running_sum <= '0;
            error_seen  <= 1'b0;
            state       <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Result valid: set on a load, cleared when the item is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == ST_FIN) && out_free) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  // Payload: item fields and result data
  always_ff @(posedge clk) begin
    if (accept) begin
      mode     <= operand.mode;
      last     <= operand.last;
      noise    <= operand.noise;
      msg_bit  <= operand.msg_bit;
      cipher_v <= operand.cipher_v;
    end
    if ((state == ST_FIN) && out_free) begin
      out_value <= fin_value;
      out_err   <= error_seen | fin_err;
    end
  end

  assign result.valid       = out_valid;
  assign result.value       = out_value;
  assign result.range_error = out_err;

`ifndef SYNTH
  // An accepted item always starts the multiplier
  a_accept_mul: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == ST_MUL) && mul_stat.busy)
    else $error("accepted item did not start multiply");

  // Multiplier completes only while the sequencer waits for it
  a_done_in_mul: assert property (@(posedge clk) disable iff (rst)
    mul_stat.done |-> (state == ST_MUL))
    else $error("multiplier done outside multiply state");

  // Finishing either holds or loads the result register
  a_fin_loads: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FIN) |=> (state == ST_FIN) || ((state == ST_IDLE) && out_valid))
    else $error("finish left without loading a result");
`endif

endmodule

// ===== rtl/lmq_modmul.sv =====
// lmq_modmul: bit-serial (sum + a*b) mod q by interleaved shift-add-subtract.
// One bit of sum and of b per cycle, MSB first; uses lmq_pkg.
module lmq_modmul #(
  parameter int W = 14
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [W-1:0]          q,
  input  logic [W-1:0]          sum_in,
  input  logic [W-1:0]          a_in,
  input  logic [W-1:0]          b_in,
  output logic [W-1:0]          result,
  output lmq_pkg::lmq_mul_stat_t stat
);
  import lmq_pkg::*;

  localparam int CntW = $clog2(W + 1);

  logic [CntW-1:0] cnt;
  logic [W-1:0]    sreg;
  logic [W-1:0]    breg;
  logic [W-1:0]    areg;
  logic [W-1:0]    p;

  logic [W:0]      dbl;
  logic [W-1:0]    dbl_red;
  logic [W:0]      acc;
  logic [W-1:0]    acc_red;

  // One Horner step: p = 2p + sum bit, reduce; then add a if b bit, reduce.
  // p < q keeps each partial below 2q, so one subtract suffices.
  always_comb begin
    dbl     = {p, sreg[W-1]};
    dbl_red = (dbl >= {1'b0, q}) ? W'(dbl - {1'b0, q}) : dbl[W-1:0];
    acc     = {1'b0, dbl_red} + (breg[W-1] ? {1'b0, areg} : {(W+1){1'b0}});
    acc_red = (acc >= {1'b0, q}) ? W'(acc - {1'b0, q}) : acc[W-1:0];
  end

  // Step counter and shift registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= CntW'(W);
    end else if (cnt != '0) begin
      cnt <= cnt - CntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      sreg <= sum_in;
      breg <= b_in;
      areg <= a_in;
      p    <= '0;
    end else if (cnt != '0) begin
      sreg <= sreg << 1;
      breg <= breg << 1;
      p    <= acc_red;
    end
  end

  assign stat.busy = (cnt != '0);
  assign stat.done = (cnt == CntW'(1));
  assign result    = acc_red;  // valid in the cycle done is high

endmodule

// ===== rtl/lmq_finish.sv =====
// lmq_finish: finishes one matrix entry from the reduced sum by mode.
// Noise/message addition or decryption threshold; uses lmq_pkg.
module lmq_finish #(
  parameter int W = 14
) (
  input  logic [1:0]   mode,
  input  logic [W-1:0] q,
  input  logic [W-1:0] sum,
  input  logic [W-1:0] noise,
  input  logic         msg_bit,
  input  logic [W-1:0] cipher_v,
  output logic [W-1:0] value,
  output logic         range_error
);
  import lmq_pkg::*;

  logic         is_dec;
  logic [W-1:0] quarter;
  logic [W-1:0] half;
  logic [W-1:0] v_chk;
  logic [W-1:0] e_chk;
  logic [W:0]   diff;
  logic [W-1:0] d;
  logic [W:0]   s1;
  logic [W-1:0] s1_red;
  logic [W:0]   s2;
  logic [W-1:0] s2_red;

  always_comb begin
    is_dec  = (mode == MODE_DEC);
    quarter = q >> 2;
    half    = q >> 1;

    // Out-of-range operands count as zero; the one the mode uses raises the flag
    v_chk = (cipher_v >= q) ? '0 : cipher_v;
    e_chk = (noise >= q) ? '0 : noise;
    range_error = is_dec ? (cipher_v >= q) : (noise >= q);

    // Decrypt: d = (v - sum) mod q
    diff = {1'b0, v_chk} - {1'b0, sum};
    d    = diff[W] ? W'(diff + {1'b0, q}) : diff[W-1:0];

    // Encode: (sum + e) mod q, then + floor(q/2) in V mode with a one bit
    s1     = {1'b0, sum} + {1'b0, e_chk};
    s1_red = (s1 >= {1'b0, q}) ? W'(s1 - {1'b0, q}) : s1[W-1:0];
    s2     = {1'b0, s1_red} + {1'b0, half};
    s2_red = (s2 >= {1'b0, q}) ? W'(s2 - {1'b0, q}) : s2[W-1:0];

    if (is_dec) begin
      value = ((d > quarter) && (d < q - quarter)) ? W'(1) : '0;
    end else if ((mode == MODE_V) && msg_bit) begin
      value = s2_red;
    end else begin
      value = s1_red;
    end
  end

endmodule

// ===== bench/lwe_mod_q_mac_codec_top_tb.sv =====
// lwe_mod_q_mac_codec_top_tb: self-checking bench for the mod-q MAC codec.
// Drives operand items; checks results against a predictor or listed values.
// Depends on lmq_pkg, lmq_if (lmq_op_if, lmq_res_if) and lwe_mod_q_mac_codec_top.
module lwe_mod_q_mac_codec_top_tb;
  import lmq_pkg::*;

  localparam int MODW = 14;
  localparam int RUN_LIMIT = 400000;
  localparam int SETTLE_CYCLES = 40;
  localparam int LONG_HOLD = 300;
  localparam int ITEMS_PER_PHASE = 88;
  localparam int NUM_PHASES = 12;
  localparam int RANDOM_MOD = -1;
  localparam logic [1:0] MODE_UNUSED = 2'd3;  // behaves as MODE_KEY

  typedef struct packed {
    logic [1:0]      mode;
    logic [MODW-1:0] a_value;
    logic [MODW-1:0] b_value;
    logic            last;
    logic [MODW-1:0] noise;
    logic            msg_bit;
    logic [MODW-1:0] cipher_v;
  } op_item_t;

  typedef struct packed {
    logic [MODW-1:0] value;
    logic            range_error;
  } res_t;

  typedef struct packed {
    op_item_t        item;
    bit              typed;
    logic [MODW-1:0] want_value;
    logic            want_err;
  } dir_row_t;

  logic            clk;
  logic            rst;
  logic            modulus_we;
  logic [MODW-1:0] modulus_data;

  lmq_op_if  #(.W(MODW)) op_ch ();
  lmq_res_if #(.W(MODW)) res_ch ();

  lwe_mod_q_mac_codec_top #(.MOD_WIDTH(MODW)) u_top (
    .clk          (clk),
    .rst          (rst),
    .modulus_we   (modulus_we),
    .modulus_data (modulus_data),
    .operand      (op_ch),
    .result       (res_ch)
  );

  // Predictor state: modulus register copy, running sum, range flag
  logic [MODW-1:0] mod_reg;
  logic [MODW-1:0] acc_sum;
  bit              err_seen;

  res_t     pending_results[$];
  dir_row_t dir_rows[$];
  int       mismatch_cnt;
  int       cycle_cnt;
  int       src_idle_pct;
  int       snk_idle_pct;
  int       hold_req;
  int       hold_done;
  int       items_sent;

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int unsigned eff_mod();
    return (mod_reg < 2) ? 2 : int'(mod_reg);
  endfunction

  // Mostly in-range residues, sometimes the edges or any 14-bit value
  function automatic logic [MODW-1:0] pick_residue();
    int unsigned q;
    int unsigned sel;
    q = eff_mod();
    sel = $urandom_range(0, 99);
    if (sel < 6) return MODW'($urandom_range(0, (1 << MODW) - 1));
    if (sel < 10) return MODW'(q - 1);
    if (sel < 13) return '0;
    return MODW'($urandom % q);
  endfunction

  // Behavioral model of one accepted operand item
  task automatic mac_predict(input op_item_t it, output bit emits, output res_t r);
    int unsigned q, s, v, d, qtr;
    q = eff_mod();
    s = int'(acc_sum) % q;
    emits = 1'b0;
    r = '0;
    if (it.a_value >= q || it.b_value >= q) err_seen = 1'b1;
    else s = (s + (int'(it.a_value) * int'(it.b_value)) % q) % q;
    if (!it.last) begin
      acc_sum = MODW'(s);
    end else begin
      if (it.mode == MODE_DEC) begin
        v = it.cipher_v;
        if (v >= q) begin
          err_seen = 1'b1;
          v = 0;
        end
        d = (v + q - s) % q;
        qtr = q / 4;
        v = (d > qtr && d < q - qtr) ? 1 : 0;
      end else begin
        v = it.noise;
        if (v >= q) begin
          err_seen = 1'b1;
          v = 0;
        end
        v = (s + v) % q;
        if (it.mode == MODE_V && it.msg_bit) v = (v + q / 2) % q;
      end
      r.value = MODW'(v);
      r.range_error = err_seen;
      emits = 1'b1;
      acc_sum = '0;
      err_seen = 1'b0;
    end
  endtask

  // Offer one item and wait for it to be taken; valid stays up afterwards
  task automatic send_item(input op_item_t it, input bit typed,
                           input logic [MODW-1:0] want_value, input logic want_err);
    bit   emits;
    res_t r;
    while ($urandom_range(0, 99) < src_idle_pct) begin
      op_ch.valid <= 1'b0;
      @(posedge clk);
    end
    op_ch.valid    <= 1'b1;
    op_ch.mode     <= it.mode;
    op_ch.a_value  <= it.a_value;
    op_ch.b_value  <= it.b_value;
    op_ch.last     <= it.last;
    op_ch.noise    <= it.noise;
    op_ch.msg_bit  <= it.msg_bit;
    op_ch.cipher_v <= it.cipher_v;
    @(posedge clk);
    while (!op_ch.ready) @(posedge clk);
    mac_predict(it, emits, r);
    if (emits) begin
      if (typed) begin
        r.value = want_value;
        r.range_error = want_err;
      end
      pending_results.push_back(r);
    end
    items_sent++;
  endtask

  // One well-formed sum: random length, mostly one mode, last on the final item
  task automatic send_random_sum();
    op_item_t it;
    int       len;
    int       sel;
    logic [1:0] sum_mode;
    sel = $urandom_range(0, 99);
    if (sel < 70) len = $urandom_range(1, 4);
    else if (sel < 95) len = $urandom_range(5, 12);
    else len = $urandom_range(13, 40);
    sum_mode = ($urandom_range(0, 9) == 0) ? MODE_UNUSED : 2'($urandom_range(0, 2));
    for (int k = 0; k < len; k++) begin
      it.mode     = ($urandom_range(0, 19) == 0) ? 2'($urandom_range(0, 3)) : sum_mode;
      it.a_value  = pick_residue();
      it.b_value  = pick_residue();
      it.last     = (k == len - 1);
      it.noise    = pick_residue();
      it.msg_bit  = 1'($urandom_range(0, 1));
      it.cipher_v = pick_residue();
      send_item(it, 1'b0, '0, 1'b0);
    end
  endtask

  // Drop valid, wait for every expected result, then let the block settle
  task automatic drain();
    op_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_modulus(input logic [MODW-1:0] val);
    modulus_we   <= 1'b1;
    modulus_data <= val;
    @(posedge clk);
    modulus_we   <= 1'b0;
    mod_reg = val;
  endtask

  task automatic add_row(input logic [1:0] mode, input int a, input int b, input bit last,
                         input int noise, input bit msg, input int cv, input bit typed,
                         input int want_value, input bit want_err);
    dir_row_t row;
    row.item.mode     = mode;
    row.item.a_value  = MODW'(a);
    row.item.b_value  = MODW'(b);
    row.item.last     = last;
    row.item.noise    = MODW'(noise);
    row.item.msg_bit  = msg;
    row.item.cipher_v = MODW'(cv);
    row.typed         = typed;
    row.want_value    = MODW'(want_value);
    row.want_err      = want_err;
    dir_rows.push_back(row);
  endtask

  // Receiver: random ready, with one long hold-off on request
  initial begin
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_done != hold_req) begin
        hold_done++;
        res_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end
      res_ch.ready <= ($urandom_range(0, 99) >= snk_idle_pct);
    end
  end

  // Result checker
  always @(posedge clk) begin
    res_t want;
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result with none expected: value=%0d range_error=%0b",
                 $time, res_ch.value, res_ch.range_error);
        mismatch_cnt++;
      end else begin
        want = pending_results.pop_front();
        if (res_ch.value !== want.value) begin
          $display("%0t: value expected %0d actual %0d", $time, want.value, res_ch.value);
          mismatch_cnt++;
        end
        if (res_ch.range_error !== want.range_error) begin
          $display("%0t: range_error expected %0b actual %0b",
                   $time, want.range_error, res_ch.range_error);
          mismatch_cnt++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > RUN_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Stimulus
  initial begin
    int mod_plan[NUM_PHASES];
    int phase_base;
    logic [MODW-1:0] new_mod;
    op_item_t it;

    mod_plan = '{0, 1, 2, 3, 16383, RANDOM_MOD, 5, RANDOM_MOD,
                 12289, RANDOM_MOD, 8209, 8210};
    mismatch_cnt = 0;
    cycle_cnt    = 0;
    hold_req     = 0;
    hold_done    = 0;
    items_sent   = 0;
    mod_reg      = MOD_RESET;
    acc_sum      = '0;
    err_seen     = 1'b0;
    src_idle_pct = 34;
    snk_idle_pct = 47;

    rst            <= 1'b1;
    modulus_we     <= 1'b0;
    modulus_data   <= '0;
    op_ch.valid    <= 1'b0;
    op_ch.mode     <= MODE_KEY;
    op_ch.a_value  <= '0;
    op_ch.b_value  <= '0;
    op_ch.last     <= 1'b0;
    op_ch.noise    <= '0;
    op_ch.msg_bit  <= 1'b0;
    op_ch.cipher_v <= '0;

    // Directed rows at the reset modulus q = 8210 (quarter 2052, half 4105)
    add_row(MODE_KEY,    0,     0,     1, 0,     0, 0,     1, 0,    0);
    add_row(MODE_KEY,    1,     1,     1, 0,     0, 0,     1, 1,    0);
    add_row(MODE_KEY,    8209,  8209,  1, 0,     0, 0,     1, 1,    0);  // (-1)*(-1)
    add_row(MODE_KEY,    8210,  1,     1, 5,     0, 0,     1, 5,    1);  // a equal to q
    add_row(MODE_KEY,    16383, 16383, 1, 0,     0, 0,     1, 0,    1);
    add_row(MODE_KEY,    3,     4,     1, 16383, 0, 0,     1, 12,   1);  // noise out of range
    add_row(MODE_KEY,    0,     0,     1, 3,     0, 16383, 1, 3,    0);  // cipher_v ignored
    add_row(MODE_KEY,    0,     0,     1, 9,     1, 0,     1, 9,    0);  // msg ignored
    add_row(MODE_V,      0,     0,     1, 0,     1, 0,     1, 4105, 0);
    add_row(MODE_V,      0,     0,     1, 8209,  1, 0,     1, 4104, 0);  // wraps
    add_row(MODE_V,      0,     0,     1, 7,     0, 0,     1, 7,    0);
    add_row(MODE_DEC,    0,     0,     1, 0,     0, 0,     1, 0,    0);
    add_row(MODE_DEC,    0,     0,     1, 0,     0, 2052,  1, 0,    0);  // on lower bound
    add_row(MODE_DEC,    0,     0,     1, 0,     0, 2053,  1, 1,    0);
    add_row(MODE_DEC,    0,     0,     1, 0,     0, 6157,  1, 1,    0);
    add_row(MODE_DEC,    0,     0,     1, 0,     0, 6158,  1, 0,    0);  // on upper bound
    add_row(MODE_DEC,    0,     0,     1, 0,     0, 16383, 1, 0,    1);  // cipher_v range
    add_row(MODE_DEC,    0,     0,     1, 16383, 0, 4000,  1, 1,    0);  // noise ignored
    add_row(MODE_UNUSED, 2,     3,     1, 1,     1, 0,     1, 7,    0);
    add_row(MODE_KEY,    100,   100,   0, 0,     0, 0,     0, 0,    0);
    add_row(MODE_V,      8209,  16383, 0, 0,     0, 0,     0, 0,    0);  // dropped product
    add_row(MODE_KEY,    2,     5,     1, 0,     0, 0,     0, 0,    0);
    add_row(MODE_KEY,    1,     100,   0, 0,     0, 0,     0, 0,    0);
    add_row(MODE_DEC,    1,     0,     1, 0,     0, 0,     0, 0,    0);  // negative d
    add_row(MODE_DEC,    8209,  1,     1, 0,     0, 0,     0, 0,    0);

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i])
      send_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].want_value,
                dir_rows[i].want_err);
    drain();

    // Random phases, one modulus each; odd phases leave a sum open
    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p < 4) begin
        src_idle_pct = 34;
        snk_idle_pct = 47;
      end else if (p < 8) begin
        src_idle_pct = 47;
        snk_idle_pct = 34;
      end else begin
        src_idle_pct = 0;
        snk_idle_pct = 0;
      end
      new_mod = (mod_plan[p] == RANDOM_MOD) ? MODW'($urandom_range(2, (1 << MODW) - 1))
                                            : MODW'(mod_plan[p]);
      write_modulus(new_mod);
      if (p == 9) hold_req++;
      phase_base = items_sent;
      while (items_sent - phase_base < ITEMS_PER_PHASE) send_random_sum();
      if (p % 2 == 1) begin
        it.mode     = MODE_KEY;
        it.a_value  = pick_residue();
        it.b_value  = pick_residue();
        it.last     = 1'b0;
        it.noise    = '0;
        it.msg_bit  = 1'b0;
        it.cipher_v = '0;
        send_item(it, 1'b0, '0, 1'b0);
      end
      drain();
    end

    if (mismatch_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
